FILE: rtl/sorted_table_search_insert_delete_top_macros.svh
// ----------------------------------------------------------------------------
// Sorted table assertion macros
// Concurrent check helpers; empty bodies when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_SEARCH_INSERT_DELETE_TOP_MACROS_SVH
`define SORTED_TABLE_SEARCH_INSERT_DELETE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define STC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted table check failed");
// next-cycle implication
`define STC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted table check failed");
`else
`define STC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define STC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table package
// Payload structs, cell command group and controller states.
// ----------------------------------------------------------------------------
package stc_pkg;

   localparam int VALUE_W    = 16;
   localparam int POSITION_W = 4;
   localparam int COUNT_W    = 5;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_code_type;

   typedef struct packed {
      logic               req_type;
      logic [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic                  found;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    entry_count;
   } rsp_payload_type;

   // broadcast to every cell
   typedef struct packed {
      logic cmp_en;
      logic upd_en;
      logic del;
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

endpackage

FILE: rtl/stc_cell.sv
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one key; compares against the request and shifts with its neighbours.
// ----------------------------------------------------------------------------
module stc_cell #(
   parameter int KEY_BITS = 16
) (
   input  logic                  clock,
   input  stc_pkg::cell_cmd_type cmd,
   input  logic [KEY_BITS-1:0]   key_req,
   input  logic                  cell_valid,
   input  logic                  lt_en,
   input  logic                  lt_prev,
   input  logic [KEY_BITS-1:0]   key_prev,
   input  logic [KEY_BITS-1:0]   key_next,
   output logic                  lt_out,
   output logic                  eq_out,
   output logic [KEY_BITS-1:0]   key_out
);
   import stc_pkg::*;

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic                lt_ff;
   logic                eq_ff;

   always_comb begin
      key_in = key_ff;
      // cells below the boundary keep their key
      if (cmd.upd_en && !lt_ff) begin
         if (cmd.del) begin
            key_in = key_next;
         end else if (lt_prev) begin
            key_in = key_req;
         end else begin
            key_in = key_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (cmd.cmp_en) begin
         lt_ff <= lt_en && cell_valid && (key_ff < key_req);
         eq_ff <= cell_valid && (key_ff == key_req);
      end
   end

   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;
   assign key_out = key_ff;

endmodule

FILE: rtl/sorted_table_search_insert_delete_top.sv
// ----------------------------------------------------------------------------
// Sorted table with search, insert and delete
// Row of key cells kept in ascending order with a valid-entry count.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken on a rising edge with start high and busy
//   low; req_payload carries the request kind (load or query) and the key.
//   In that edge every cell compares its key with the request at once.
//   During the following cycle busy is high, the single boundary cell is
//   found from the registered flags, and the cells shift up (insert) or down
//   (delete) together with their neighbours.
//   Exactly one result transaction follows each request: rsp_strobe is high
//   for one cycle, registered at the end of the update cycle, with found,
//   position and the new entry_count in rsp_payload.
//   Busy holds off a new request until the parallel compare and the parallel
//   shift of the last one are done, for any table depth.
//   The receiver cannot stall; results are not held back.
//   Reset empties the table by clearing the count; cell keys are not cleared
//   and slots beyond the count are never used.
// ----------------------------------------------------------------------------
`include "sorted_table_search_insert_delete_top_macros.svh"

module sorted_table_search_insert_delete_top #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  stc_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output stc_pkg::rsp_payload_type rsp_payload
);
   import stc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type              state_ff;
   state_type              state_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [KEY_BITS-1:0]    key_ff;
   logic                   query_ff;
   logic [KEY_BITS-1:0]    key_live;
   logic [KEY_BITS-1:0]    key_bcast;
   logic                   accept;
   cell_cmd_type           cmd;
   logic                   hit;
   logic [IDX_W-1:0]       pos;
   logic                   rsp_strobe_ff;
   rsp_payload_type        rsp_payload_ff;

   logic [TABLE_DEPTH-1:0] lt;
   logic [TABLE_DEPTH-1:0] eq;
   logic [TABLE_DEPTH-1:0] boundary;
   logic [KEY_BITS-1:0]    keys [TABLE_DEPTH];

   assign busy     = (state_ff == ST_UPDATE);
   assign accept   = start && !busy;
   assign key_live = KEY_BITS'(req_payload.value);
   assign key_bcast = busy ? key_ff : key_live;

   // exactly one cell sits at the first not-smaller slot
   always_comb begin
      hit = 1'b0;
      pos = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         boundary[i] = !lt[i] && ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]);
         if (boundary[i]) begin
            pos = pos | IDX_W'(i);
            hit = hit | eq[i];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.cmp_en = 1'b0;
      cmd.upd_en = 1'b0;
      cmd.del    = 1'b0;
      count_in   = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.cmp_en = accept;
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.upd_en = 1'b1;
            cmd.del    = query_ff && hit;
            state_in   = ST_IDLE;
            if (cmd.del) begin
               count_in = count_ff - 1'b1;
            end else if (count_ff != CNT_W'(TABLE_DEPTH)) begin
               count_in = count_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.upd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff   <= key_live;
         query_ff <= (req_payload.req_type == REQ_QUERY);
      end
      if (cmd.upd_en) begin
         rsp_payload_ff.found       <= cmd.del;
         rsp_payload_ff.position    <= POSITION_W'(pos);
         rsp_payload_ff.entry_count <= COUNT_W'(count_in);
      end
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      localparam int PREV = (g == 0) ? 0 : g - 1;
      localparam int NEXT = (g == TABLE_DEPTH - 1) ? g : g + 1;

      stc_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .key_req    (key_bcast),
         .cell_valid (CNT_W'(g) < count_ff),
         .lt_en      ((g == TABLE_DEPTH - 1) ? 1'b0 : 1'b1),
         .lt_prev    ((g == 0) ? 1'b1 : lt[PREV]),
         .key_prev   (keys[PREV]),
         .key_next   (keys[NEXT]),
         .lt_out     (lt[g]),
         .eq_out     (eq[g]),
         .key_out    (keys[g])
      );
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   `STC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `STC_ASSERT_NEXT(a_update_result, clock, reset, busy, rsp_strobe && !busy)
   `STC_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `STC_ASSERT_IMPLY(a_found_shrinks, clock, reset, rsp_strobe && rsp_payload.found,
                     (count_ff + 1'b1) == $past(count_ff))

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Sorted table search/insert/delete testbench
// Sends load and query transactions and keeps a shadow of the sorted table.
// Each result is checked field by field against the shadow's prediction.
// Directed cases come first, then random traffic in fill, drain and mixed
// episodes, with three levels of sender idling.
// ----------------------------------------------------------------------------
module tb;
   import stc_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_payload;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;

   sorted_table_search_insert_delete_top #(
      .TABLE_DEPTH (DEPTH),
      .KEY_BITS    (VALUE_W)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // shadow of the table
   logic [VALUE_W-1:0] table_keys [DEPTH];
   int                 entry_total;

   rsp_payload_type awaited_outcomes[$];
   int              error_count;
   int              requests_sent;
   int              results_seen;
   int              deletions;
   int              full_inserts;
   int              empty_hits;
   int              sender_idle_pct;
   int              cycle_count;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d results outstanding", $time,
                  awaited_outcomes.size());
         $display("status: fail");
         $finish;
      end
   end

   // Updates the shadow table for one request and returns the result due.
   function automatic rsp_payload_type apply_to_table(req_code_type kind,
                                                      logic [VALUE_W-1:0] key);
      rsp_payload_type outcome;
      int              slot;
      int              i;
      bit              hit;
      slot = 0;
      hit  = 1'b0;
      if (kind == REQ_QUERY) begin
         for (i = 0; i < entry_total; i++) begin
            if (!hit && table_keys[i] == key) begin
               hit  = 1'b1;
               slot = i;
            end
         end
      end
      if (hit) begin
         for (i = slot; i + 1 < entry_total; i++)
            table_keys[i] = table_keys[i + 1];
         entry_total--;
         deletions++;
         if (entry_total == 0)
            empty_hits++;
      end else begin
         for (i = 0; i < entry_total; i++)
            if (table_keys[i] < key)
               slot++;
         if (entry_total == DEPTH) begin
            // largest entry falls off the end
            full_inserts++;
            if (slot == DEPTH)
               slot = DEPTH - 1;
            for (i = DEPTH - 1; i > slot; i--)
               table_keys[i] = table_keys[i - 1];
         end else begin
            for (i = entry_total; i > slot; i--)
               table_keys[i] = table_keys[i - 1];
            entry_total++;
         end
         table_keys[slot] = key;
      end
      outcome.found       = hit;
      outcome.position    = slot[POSITION_W-1:0];
      outcome.entry_count = entry_total[COUNT_W-1:0];
      return outcome;
   endfunction

   // Called at a falling edge; returns at a falling edge.
   task automatic send_request(req_code_type kind, logic [VALUE_W-1:0] key);
      req_payload_type item;
      item.req_type = kind;
      item.value    = key;
      start       <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      awaited_outcomes.push_back(apply_to_table(kind, key));
      requests_sent++;
      @(negedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4))
            @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         results_seen++;
         if (awaited_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result found=%0d position=%0d entry_count=%0d",
                     $time, rsp_payload.found, rsp_payload.position,
                     rsp_payload.entry_count);
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_payload.found !== want.found ||
                rsp_payload.position !== want.position ||
                rsp_payload.entry_count !== want.entry_count) begin
               error_count++;
               $display("%0t: mismatch expected found=%0d position=%0d entry_count=%0d, got found=%0d position=%0d entry_count=%0d",
                        $time, want.found, want.position, want.entry_count,
                        rsp_payload.found, rsp_payload.position,
                        rsp_payload.entry_count);
            end
         end
      end
   end

   task automatic test_empty_table();
      send_request(REQ_QUERY, 16'h0000);   // insert into empty table
      send_request(REQ_LOAD,  16'hFFFF);
      send_request(REQ_QUERY, 16'hFFFF);   // delete top entry
      send_request(REQ_QUERY, 16'h0000);   // back to empty
   endtask

   task automatic test_equal_keys();
      send_request(REQ_LOAD,  16'h0005);
      send_request(REQ_LOAD,  16'h0005);
      send_request(REQ_QUERY, 16'h0005);   // first of the pair goes
   endtask

   task automatic test_full_table();
      int i;
      for (i = 1; i < DEPTH; i++)
         send_request(REQ_LOAD, 16'(i * 4000 + 7));
      send_request(REQ_QUERY, 16'hFFFF);   // above all: replaces last slot
      send_request(REQ_LOAD,  16'h0000);   // below all: top entry dropped
      send_request(REQ_QUERY, 16'(8 * 4000 + 7));
   endtask

   function automatic logic [VALUE_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15)
         return VALUE_W'($urandom_range(15));
      else if (roll < 20)
         return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      return VALUE_W'($urandom);
   endfunction

   // Every 40 requests a filling, draining or mixed episode is picked at random so the
   // table swings between empty and full.
   task automatic random_phase(int total, int idle_pct);
      int           n;
      int           load_pct;
      int           hit_pct;
      req_code_type kind;
      logic [VALUE_W-1:0] key;
      sender_idle_pct = idle_pct;
      load_pct = 40;
      hit_pct  = 50;
      for (n = 0; n < total; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0: begin
                  load_pct = 75;
                  hit_pct  = 20;
               end
               1: begin
                  load_pct = 10;
                  hit_pct  = 90;
               end
               default: begin
                  load_pct = 40;
                  hit_pct  = 50;
               end
            endcase
         end
         kind = ($urandom_range(99) < load_pct) ? REQ_LOAD : REQ_QUERY;
         if (kind == REQ_QUERY && entry_total > 0 && $urandom_range(99) < hit_pct)
            key = table_keys[$urandom_range(entry_total - 1)];
         else
            key = pick_key();
         send_request(kind, key);
      end
   endtask

   task automatic test_random_traffic();
      random_phase(400, 19);
      random_phase(350, 70);
      random_phase(400, 0);
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_payload     = '0;
      entry_total     = 0;
      error_count     = 0;
      requests_sent   = 0;
      results_seen    = 0;
      deletions       = 0;
      full_inserts    = 0;
      empty_hits      = 0;
      cycle_count     = 0;
      sender_idle_pct = 19;
      repeat (7)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_equal_keys();
      test_full_table();
      test_random_traffic();

      start <= 1'b0;
      while (awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (6)
         @(posedge clock);

      $display("%0d requests, %0d results checked: %0d deletions, %0d inserts on a full table",
               requests_sent, results_seen, deletions, full_inserts);
      $display("table emptied by deletion %0d times, %0d mismatches", empty_hits,
               error_count);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
